// ===== rtl/fegen_pkg.sv =====
// ----------------------------------------------------------------------------
// fegen_pkg
// Types, constants and the control program of the fade envelope generator.
// ----------------------------------------------------------------------------
`default_nettype none

package fegen_pkg;

	// Configuration port geometry and register indexes.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_FADE_IN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FADE_OUT = 2'd2;

	localparam logic [CFG_DATA_W-1:0] FADE_IN_RST  = 16'd200;
	localparam logic [CFG_DATA_W-1:0] HOLD_RST     = 16'd1000;
	localparam logic [CFG_DATA_W-1:0] FADE_OUT_RST = 16'd300;

	// Elapsed time and time advance width in milliseconds.
	localparam int MS_W = 16;

	typedef enum logic [1:0] {
		PH_FADE_IN  = 2'd0,
		PH_HOLD     = 2'd1,
		PH_FADE_OUT = 2'd2,
		PH_DONE     = 2'd3
	} phase_t;

	// Datapath operations, one per control word.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_ADD,
		OP_DECIDE,
		OP_DIV,
		OP_FORMX,
		OP_SQ,
		OP_CUBE,
		OP_FIN,
		OP_EMIT
	} op_t;

	// Conditions under which the step counter holds its value.
	typedef enum logic [1:0] {
		W_NONE,
		W_NO_ITEM,
		W_DIV_MORE,
		W_OUT_BUSY
	} wait_t;

	// Conditions under which the step counter jumps to the target.
	typedef enum logic [1:0] {
		J_NONE,
		J_ALWAYS,
		J_NO_DIV
	} jump_t;

	localparam int STEP_W = 4;

	localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
	localparam logic [STEP_W-1:0] STEP_ADD    = 4'd1;
	localparam logic [STEP_W-1:0] STEP_DECIDE = 4'd2;
	localparam logic [STEP_W-1:0] STEP_DIV    = 4'd3;
	localparam logic [STEP_W-1:0] STEP_FORMX  = 4'd4;
	localparam logic [STEP_W-1:0] STEP_SQ     = 4'd5;
	localparam logic [STEP_W-1:0] STEP_CUBE   = 4'd6;
	localparam logic [STEP_W-1:0] STEP_FIN    = 4'd7;
	localparam logic [STEP_W-1:0] STEP_EMIT   = 4'd8;

	typedef struct packed {
		op_t                op;
		wait_t              wait_c;
		jump_t              jump_c;
		logic [STEP_W-1:0]  target;
	} ctrl_t;

	// Status flags that the datapath returns to the sequencer.
	typedef struct packed {
		logic item_accept;
		logic out_free;
		logic div_more;
		logic need_div;
	} status_t;

	// The control program.
	function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
		ctrl_t w;
		w = '{op: OP_NOP, wait_c: W_NONE, jump_c: J_ALWAYS, target: STEP_IDLE};
		case (step)
			STEP_IDLE:   w = '{op: OP_LOAD,   wait_c: W_NO_ITEM,  jump_c: J_NONE,
				target: STEP_IDLE};
			STEP_ADD:    w = '{op: OP_ADD,    wait_c: W_NONE,     jump_c: J_NONE,
				target: STEP_IDLE};
			STEP_DECIDE: w = '{op: OP_DECIDE, wait_c: W_NONE,     jump_c: J_NO_DIV,
				target: STEP_EMIT};
			STEP_DIV:    w = '{op: OP_DIV,    wait_c: W_DIV_MORE, jump_c: J_NONE,
				target: STEP_IDLE};
			STEP_FORMX:  w = '{op: OP_FORMX,  wait_c: W_NONE,     jump_c: J_NONE,
				target: STEP_IDLE};
			STEP_SQ:     w = '{op: OP_SQ,     wait_c: W_NONE,     jump_c: J_NONE,
				target: STEP_IDLE};
			STEP_CUBE:   w = '{op: OP_CUBE,   wait_c: W_NONE,     jump_c: J_NONE,
				target: STEP_IDLE};
			STEP_FIN:    w = '{op: OP_FIN,    wait_c: W_NONE,     jump_c: J_NONE,
				target: STEP_IDLE};
			STEP_EMIT:   w = '{op: OP_EMIT,   wait_c: W_OUT_BUSY, jump_c: J_ALWAYS,
				target: STEP_IDLE};
			default:     w = '{op: OP_NOP,    wait_c: W_NONE,     jump_c: J_ALWAYS,
				target: STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/fegen_if.sv =====
// ----------------------------------------------------------------------------
// fegen_if
// Valid/ready channels of the fade envelope generator: time advance words in,
// opacity words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface fegen_item_if;
	logic        valid;
	logic        ready;
	logic        restart;
	logic [15:0] delta_ms;

	modport source (output valid, output restart, output delta_ms, input ready);
	modport sink   (input valid, input restart, input delta_ms, output ready);
endinterface

interface fegen_result_if #(
	parameter int OPACITY_BITS = 16
);
	logic                    valid;
	logic                    ready;
	logic [OPACITY_BITS-1:0] opacity;
	logic [1:0]              phase;
	logic                    active;

	modport source (output valid, output opacity, output phase, output active,
		input ready);
	modport sink   (input valid, input opacity, input phase, input active,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/fade_envelope_generator_core.sv =====
// ----------------------------------------------------------------------------
// fade_envelope_generator_core
// Opacity envelope with fade-in, hold, fade-out and done phases, run by a
// small control program over a shared divide and multiply datapath.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Word contents                  Handshake
//   item      in         restart, delta_ms              valid/ready
//   result    out        opacity, phase, active         valid/ready
//   cfg       in         cfg_idx, cfg_wdata             cfg_we, no wait
//
// A word that needs the easing curve is loaded into the result register after
// the add, decide, divide, form-x, square, cube and finish steps; the divide
// step is the one-bit-per-cycle restoring divider that forms t and repeats
// once per quotient bit. Only then does the program return to its idle step
// to take the next word. Words in hold, at the end of a phase or in done go
// from the decide step straight to the load step. Reset leaves the phase in done,
// elapsed time and opacity at zero, and the durations at 200, 1000 and 300 ms.
// The result register frees the input side: a new word is taken while an
// earlier result still waits, and only the final load step stalls on it.
//
`default_nettype none

module fade_envelope_generator_core #(
	parameter int OPACITY_BITS = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [fegen_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [fegen_pkg::CFG_DATA_W-1:0] cfg_wdata,
	fegen_item_if.sink                            item,
	fegen_result_if.source                        result
);

	// Quotient t has OPACITY_BITS fraction bits. The eased operand x and the
	// square and cube can reach exactly 1.0, so they carry one extra bit.
	localparam int OB = OPACITY_BITS;
	localparam int XW = OB + 1;
	localparam int PW = 2 * XW;
	localparam int CW = $clog2(OB + 1);
	localparam int MW = fegen_pkg::MS_W;

	localparam logic [XW-1:0] ONE_Q  = {1'b1, {OB{1'b0}}};
	localparam logic [OB-1:0] FULL_Q = {OB{1'b1}};

	fegen_pkg::ctrl_t   ctrl;
	fegen_pkg::status_t stat;

	// Configuration registers.
	logic [MW-1:0] fade_in_q;
	logic [MW-1:0] hold_q;
	logic [MW-1:0] fade_out_q;

	// Envelope state.
	fegen_pkg::phase_t phase_q;
	logic [MW-1:0]     elapsed_q;
	logic [OB-1:0]     opacity_q;

	// Working registers of the datapath.
	logic [MW-1:0] delta_q;
	logic [MW-1:0] rem_q;
	logic [OB-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic [XW-1:0] x_q;
	logic [XW-1:0] acc_q;

	// Result register.
	logic          out_valid_q;
	logic [OB-1:0] out_opacity_q;
	logic [1:0]    out_phase_q;
	logic          out_active_q;

	logic          item_accept;
	logic          out_free;
	logic [MW:0]   sum;
	logic [MW-1:0] elapsed_sat;
	logic [MW-1:0] den;
	logic [MW:0]   rem_sh;
	logic [MW:0]   rem_sub;
	logic          rem_ge;
	logic          need_div;
	logic [XW-1:0] x_form;
	logic [XW-1:0] mul_a;
	logic [PW-1:0] mul_p;
	logic [XW-1:0] mul_hi;
	logic [XW-1:0] fin_diff;
	logic [OB-1:0] fin_opa;

	fegen_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// Words are taken only in the idle step of the program.
	assign item.ready  = (ctrl.op == fegen_pkg::OP_LOAD);
	assign item_accept = item.valid && item.ready;

	// The result register can take a new word when it is empty or is being
	// drained in this same cycle.
	assign out_free = !out_valid_q || result.ready;

	assign result.valid   = out_valid_q;
	assign result.opacity = out_opacity_q;
	assign result.phase   = out_phase_q;
	assign result.active  = out_active_q;

	// Elapsed time saturates at the top of its range.
	assign sum         = {1'b0, elapsed_q} + {1'b0, delta_q};
	assign elapsed_sat = sum[MW] ? {MW{1'b1}} : sum[MW-1:0];

	// The divisor is the duration of the phase being eased.
	assign den = (phase_q == fegen_pkg::PH_FADE_OUT) ? fade_out_q : fade_in_q;

	// One restoring division step: the partial remainder stays below the
	// divisor, so the shifted value fits one extra bit and the new remainder
	// fits the original width again.
	assign rem_sh  = {rem_q, 1'b0};
	assign rem_ge  = (rem_sh >= {1'b0, den});
	assign rem_sub = rem_sh - {1'b0, den};

	// The curve is needed only while a fade is still running; every other
	// case resolves in the decide step.
	assign need_div = ((phase_q == fegen_pkg::PH_FADE_IN) && (elapsed_q < fade_in_q)) ||
		((phase_q == fegen_pkg::PH_FADE_OUT) && (elapsed_q < fade_out_q));

	// Fade-in eases on 1 - t, fade-out on t itself.
	assign x_form = (phase_q == fegen_pkg::PH_FADE_IN) ? (ONE_Q - {1'b0, quo_q})
		: {1'b0, quo_q};

	// A single multiplier serves the square and then the cube; each product
	// is truncated back to OB fraction bits.
	assign mul_a  = (ctrl.op == fegen_pkg::OP_CUBE) ? acc_q : x_q;
	assign mul_p  = PW'(mul_a) * PW'(x_q);
	assign mul_hi = mul_p[OB +: XW];

	// 1 - cube lies in [0, 1.0]; exactly 1.0 is clipped to full scale.
	assign fin_diff = ONE_Q - acc_q;
	assign fin_opa  = fin_diff[OB] ? FULL_Q : fin_diff[OB-1:0];

	assign stat.item_accept = item_accept;
	assign stat.out_free    = out_free;
	assign stat.div_more    = (cnt_q != CW'(1));
	assign stat.need_div    = need_div;

	// Control and envelope state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_in_q   <= fegen_pkg::FADE_IN_RST;
			hold_q      <= fegen_pkg::HOLD_RST;
			fade_out_q  <= fegen_pkg::FADE_OUT_RST;
			phase_q     <= fegen_pkg::PH_DONE;
			elapsed_q   <= '0;
			opacity_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					fegen_pkg::CFG_FADE_IN:  fade_in_q  <= cfg_wdata;
					fegen_pkg::CFG_HOLD:     hold_q     <= cfg_wdata;
					fegen_pkg::CFG_FADE_OUT: fade_out_q <= cfg_wdata;
					default: ;
				endcase
			end

			case (ctrl.op)
				fegen_pkg::OP_LOAD: begin
					// A restart enters fade-in with elapsed time cleared
					// before the advance is added.
					if (item_accept && item.restart) begin
						phase_q   <= fegen_pkg::PH_FADE_IN;
						elapsed_q <= '0;
					end
				end
				fegen_pkg::OP_ADD: begin
					elapsed_q <= elapsed_sat;
				end
				fegen_pkg::OP_DECIDE: begin
					case (phase_q)
						fegen_pkg::PH_FADE_IN: begin
							if (!need_div) begin
								opacity_q <= FULL_Q;
								phase_q   <= fegen_pkg::PH_HOLD;
								elapsed_q <= '0;
							end
						end
						fegen_pkg::PH_HOLD: begin
							opacity_q <= FULL_Q;
							if (elapsed_q >= hold_q) begin
								phase_q   <= fegen_pkg::PH_FADE_OUT;
								elapsed_q <= '0;
							end
						end
						fegen_pkg::PH_FADE_OUT: begin
							// Elapsed time keeps running on into done.
							if (!need_div) begin
								opacity_q <= '0;
								phase_q   <= fegen_pkg::PH_DONE;
							end
						end
						default: ;
					endcase
				end
				fegen_pkg::OP_FIN: begin
					opacity_q <= fin_opa;
				end
				default: ;
			endcase

			if ((ctrl.op == fegen_pkg::OP_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers and result payload.
	always_ff @(posedge clk) begin
		case (ctrl.op)
			fegen_pkg::OP_LOAD: begin
				if (item_accept) begin
					delta_q <= item.delta_ms;
				end
			end
			fegen_pkg::OP_DECIDE: begin
				rem_q <= elapsed_q;
				quo_q <= '0;
				cnt_q <= CW'(OB);
			end
			fegen_pkg::OP_DIV: begin
				rem_q <= rem_ge ? rem_sub[MW-1:0] : rem_sh[MW-1:0];
				quo_q <= {quo_q[OB-2:0], rem_ge};
				cnt_q <= cnt_q - CW'(1);
			end
			fegen_pkg::OP_FORMX: begin
				x_q <= x_form;
			end
			fegen_pkg::OP_SQ: begin
				acc_q <= mul_hi;
			end
			fegen_pkg::OP_CUBE: begin
				acc_q <= mul_hi;
			end
			fegen_pkg::OP_EMIT: begin
				if (out_free) begin
					out_opacity_q <= opacity_q;
					out_phase_q   <= phase_q;
					out_active_q  <= (phase_q != fegen_pkg::PH_DONE);
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/fegen_seq.sv =====
// ----------------------------------------------------------------------------
// fegen_seq
// Step counter and control store: issues one control word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fegen_seq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fegen_pkg::status_t stat,
	output fegen_pkg::ctrl_t       ctrl
);

	logic [fegen_pkg::STEP_W-1:0] step_q;
	logic [fegen_pkg::STEP_W-1:0] step_nxt;
	logic                         hold_step;
	logic                         take_jump;

	assign ctrl = fegen_pkg::ucode(step_q);

	always_comb begin
		case (ctrl.wait_c)
			fegen_pkg::W_NO_ITEM:  hold_step = !stat.item_accept;
			fegen_pkg::W_DIV_MORE: hold_step = stat.div_more;
			fegen_pkg::W_OUT_BUSY: hold_step = !stat.out_free;
			default:               hold_step = 1'b0;
		endcase

		case (ctrl.jump_c)
			fegen_pkg::J_ALWAYS: take_jump = 1'b1;
			fegen_pkg::J_NO_DIV: take_jump = !stat.need_div;
			default:             take_jump = 1'b0;
		endcase

		if (hold_step) begin
			step_nxt = step_q;
		end else if (take_jump) begin
			step_nxt = ctrl.target;
		end else begin
			step_nxt = step_q + fegen_pkg::STEP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= fegen_pkg::STEP_IDLE;
		end else begin
			step_q <= step_nxt;
		end
	end

endmodule

`default_nettype wire
